>>> src/imm_pkg.sv
// Types and codes shared by the integer matrix multiplier.
package imm_pkg;

    // Command codes carried in the cmd field
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
    localparam int CFG_DATA_W = 4;

    localparam int IN_ELEM_W = 16;
    localparam int PV_W      = 35;
    localparam int IDX_W     = 3;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic signed [IN_ELEM_W-1:0] elem_value;
    } t_in_item;

    typedef struct packed {
        logic signed [PV_W-1:0] product_value;
        logic [IDX_W-1:0]       out_row;
        logic [IDX_W-1:0]       out_col;
        logic                   last_elem;
    } t_out_item;

    // Control tag that travels alongside each operand pair
    typedef struct packed {
        logic             valid;
        logic             first_k;
        logic             last_k;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_pipe_tag;

endpackage

>>> src/integer_matrix_multiply_top.sv
// Integer matrix multiplier: operand stores, dot-product pipeline and output register.
//
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries commands:
//   load an A element, load a B element, or compute. Loads fill A and then B
//   in row-major order; loads past rows_a*inner_dim (A) or inner_dim*cols_b
//   (B) are dropped. A compute emits rows_a*cols_b results on the output
//   channel (o_out_valid / i_out_stall / o_out_item) in row-major order, the
//   final one flagged by last_elem; its acceptance rewinds both load pointers.
//   Dimensions are written through the plain write port (i_cfg_*) while idle;
//   0 reads as 1 and values above MAX_DIM read as MAX_DIM.
// Timing
//   Loads are accepted back to back while idle. A compute holds the input
//   side until its final result is taken into the output register: each
//   unstalled cycle one A and one B element come from the single read port
//   of each store, then a registered multiply, then the accumulate, whose
//   final sum for each result goes into the output register.
// Reset and stall
//   Synchronous active-low reset clears the dimensions to 1, the load pointers
//   and all valid flags; the store contents are undefined until loaded.
//   A stalled output holds its result and freezes the whole pipeline in place.
module integer_matrix_multiply_top
    import imm_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input transfer channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // result transfer channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 1;               // pointer: can hold DEPTH itself
    localparam int DW    = $clog2(MAX_DIM + 1);  // clamped dimension
    localparam int IW    = $clog2(MAX_DIM);      // row / column / inner counters
    localparam int ACC_W = 2 * ELEM_BITS + $clog2(MAX_DIM) + 1;

    typedef logic signed [ELEM_BITS-1:0]   t_elem;
    typedef logic signed [2*ELEM_BITS-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [PV_W-1:0]        t_pv;

    // configuration registers (raw) and clamped views
    logic [CFG_DATA_W-1:0] r_rows_raw, r_inner_raw, r_cols_raw;
    logic [DW-1:0]         w_ra, w_kd, w_cb;

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] raw);
        logic [DW-1:0] res;
        if (raw == '0) begin
            res = DW'(1);
        end else if (raw > CFG_DATA_W'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(raw);
        end
        return res;
    endfunction

    assign w_ra = clamp_dim(r_rows_raw);
    assign w_kd = clamp_dim(r_inner_raw);
    assign w_cb = clamp_dim(r_cols_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_raw  <= CFG_DATA_W'(1);
            r_inner_raw <= CFG_DATA_W'(1);
            r_cols_raw  <= CFG_DATA_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    r_rows_raw  <= i_cfg_data;
                CFG_INNER_DIM: r_inner_raw <= i_cfg_data;
                CFG_COLS_B:    r_cols_raw  <= i_cfg_data;
                default: ;    // unused index: write ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic            r_busy;        // compute in progress, input held off
    logic            r_run;         // address issue active
    logic [IW-1:0]   r_i, r_j, r_k;
    logic [PW-1:0]   r_ptr_a, r_ptr_b;
    t_pipe_tag       r_s1_tag, r_s2_tag, w_s0_tag;
    logic            w_pipe_en;
    logic            w_in_xfer;
    logic            w_we_a, w_we_b;
    logic [PW-1:0]   w_lim_a, w_lim_b;
    logic [PW-1:0]   w_addr_a, w_addr_b;
    logic            w_k_end, w_j_end, w_i_end;
    logic            w_done;
    t_elem           w_elem;

    // pipeline only moves when the output register can take a result
    assign w_pipe_en = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_busy;
    assign w_in_xfer  = i_in_valid && !r_busy;

    assign w_lim_a = PW'(w_ra) * PW'(w_kd);
    assign w_lim_b = PW'(w_kd) * PW'(w_cb);
    assign w_we_a  = w_in_xfer && (i_in_item.cmd == CMD_LOAD_A) && (r_ptr_a < w_lim_a);
    assign w_we_b  = w_in_xfer && (i_in_item.cmd == CMD_LOAD_B) && (r_ptr_b < w_lim_b);
    // sign-extends or truncates to the stored width
    assign w_elem  = t_elem'(i_in_item.elem_value);

    // row-major addresses, always below DEPTH for clamped dimensions
    assign w_addr_a = PW'(r_i) * PW'(w_kd) + PW'(r_k);
    assign w_addr_b = PW'(r_k) * PW'(w_cb) + PW'(r_j);

    assign w_k_end = (r_k == IW'(w_kd - DW'(1)));
    assign w_j_end = (r_j == IW'(w_cb - DW'(1)));
    assign w_i_end = (r_i == IW'(w_ra - DW'(1)));

    always_comb begin
        w_s0_tag           = '0;
        w_s0_tag.valid     = r_run;
        w_s0_tag.first_k   = (r_k == '0);
        w_s0_tag.last_k    = w_k_end;
        w_s0_tag.last_elem = w_k_end && w_j_end && w_i_end;
        w_s0_tag.row       = IDX_W'(r_i);
        w_s0_tag.col       = IDX_W'(r_j);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_ptr_a <= '0;
            r_ptr_b <= '0;
        end else begin
            if (w_we_a) r_ptr_a <= r_ptr_a + PW'(1);
            if (w_we_b) r_ptr_b <= r_ptr_b + PW'(1);
            if (w_in_xfer && i_in_item.cmd == CMD_COMPUTE) begin
                // next loads start a fresh pair of matrices
                r_run   <= 1'b1;
                r_i     <= '0;
                r_j     <= '0;
                r_k     <= '0;
                r_ptr_a <= '0;
                r_ptr_b <= '0;
            end else if (r_run && w_pipe_en) begin
                if (!w_k_end) begin
                    r_k <= r_k + IW'(1);
                end else begin
                    r_k <= '0;
                    if (!w_j_end) begin
                        r_j <= r_j + IW'(1);
                    end else begin
                        r_j <= '0;
                        if (w_i_end) r_run <= 1'b0;
                        else         r_i   <= r_i + IW'(1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Operand stores: one write per cycle and one registered read per unstalled cycle each
    // ------------------------------------------------------------------
    t_elem r_mem_a [DEPTH];
    t_elem r_mem_b [DEPTH];
    t_elem r_rd_a, r_rd_b;

    always_ff @(posedge i_clk) begin
        if (w_we_a) r_mem_a[r_ptr_a[AW-1:0]] <= w_elem;
        if (w_pipe_en) r_rd_a <= r_mem_a[w_addr_a[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) r_mem_b[r_ptr_b[AW-1:0]] <= w_elem;
        if (w_pipe_en) r_rd_b <= r_mem_b[w_addr_b[AW-1:0]];
    end

    // ------------------------------------------------------------------
    // Multiply, accumulate, output register
    // ------------------------------------------------------------------
    t_prod r_prod;
    t_acc  r_acc;
    t_acc  w_sum;
    t_out_item r_out;
    logic      r_out_valid;

    assign w_sum  = (r_s2_tag.first_k ? t_acc'(0) : r_acc) + t_acc'(r_prod);
    assign w_done = w_pipe_en && r_s2_tag.valid && r_s2_tag.last_k;

    always_ff @(posedge i_clk) begin
        if (w_pipe_en) begin
            r_prod <= r_rd_a * r_rd_b;
            if (r_s2_tag.valid) r_acc <= w_sum;
        end
        if (w_done) begin
            r_out.product_value <= t_pv'(w_sum);
            r_out.out_row       <= r_s2_tag.row;
            r_out.out_col       <= r_s2_tag.col;
            r_out.last_elem     <= r_s2_tag.last_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag    <= '0;
            r_s2_tag    <= '0;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            if (w_pipe_en) begin
                r_s1_tag    <= w_s0_tag;
                r_s2_tag    <= r_s1_tag;
                r_out_valid <= r_s2_tag.valid && r_s2_tag.last_k;
            end
            if (w_in_xfer && i_in_item.cmd == CMD_COMPUTE) begin
                r_busy <= 1'b1;
            end else if (w_done && r_s2_tag.last_elem) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    // issue only happens inside a compute
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_busy)
        else $error("address issue outside a compute");

    // operands in flight only while a compute is under way
    a_pipe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_tag.valid || r_s2_tag.valid) |-> r_busy)
        else $error("pipeline data while idle");

    // final result releases the input side
    a_last_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_s2_tag.last_elem) |=> (!r_busy && o_out_valid && o_out_item.last_elem))
        else $error("final result did not end the compute");

    // load pointers stay within the store
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr_a <= PW'(DEPTH)) && (r_ptr_b <= PW'(DEPTH)))
        else $error("load pointer beyond store depth");
`endif

endmodule
